// ----- sv/htc_pkg.sv -----
// Shared types and constants of the HTML text cleaner.
`timescale 1ns / 1ps

package htc_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        text_done;
        logic [15:0] text_length;
        logic        run_last;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic fail;
        logic done;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic work;
        logic ent_open;
        logic held_valid;
        logic out_free;
    } t_stat;

    typedef enum logic [2:0] {
        MODE_TEXT   = 3'b001,
        MODE_TAG    = 3'b010,
        MODE_ENTITY = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    localparam int N_ENT = 9;
    localparam int WINDOW_LEN = 10;
    localparam logic [9:0] NUM_CAP = 10'd512;
    localparam logic [13:0] NUM_SAT = 14'd1023;
    localparam logic [15:0] LIMIT_RESET = 16'd1024;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] ENT_SEQ [N_ENT][8] = '{
        '{"&", "a", "m", "p", ";", 8'h00, 8'h00, 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";", 8'h00, 8'h00},
        '{"&", "#", "3", "9", ";", 8'h00, 8'h00, 8'h00},
        '{"&", "n", "b", "s", "p", ";", 8'h00, 8'h00},
        '{"&", "e", "n", "s", "p", ";", 8'h00, 8'h00},
        '{"&", "e", "m", "s", "p", ";", 8'h00, 8'h00},
        '{"&", "m", "i", "d", "d", "o", "t", ";"}
    };

    localparam logic [3:0] ENT_LEN [N_ENT] = '{
        4'd5, 4'd4, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd8
    };

    localparam logic [7:0] ENT_VAL [N_ENT] = '{
        8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20, 8'h20, 8'h20, 8'h20
    };

endpackage

// ----- sv/htc_ctrl.sv -----
// Controller state machine of the HTML text cleaner.
`timescale 1ns / 1ps

module htc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last,
    input  htc_pkg::t_stat i_stat,
    output logic           o_ready,
    output htc_pkg::t_cmd  o_cmd
);

    htc_pkg::t_state r_state, n_state;
    logic r_last, n_last;
    logic go;

    assign o_ready = (r_state == htc_pkg::ST_IDLE);
    assign go = !i_stat.held_valid || i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_last = r_last;
        o_cmd = '0;
        unique case (r_state)
            htc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last = i_last;
                    n_state = htc_pkg::ST_RUN;
                end
            end
            htc_pkg::ST_RUN: begin
                if (go) begin
                    if (i_stat.work) begin
                        o_cmd.step = 1'b1;
                    end else if (r_last && i_stat.ent_open) begin
                        o_cmd.fail = 1'b1;
                    end else if (r_last) begin
                        o_cmd.done = 1'b1;
                        n_state = htc_pkg::ST_FIN;
                    end else begin
                        o_cmd.flush = i_stat.held_valid;
                        n_state = htc_pkg::ST_IDLE;
                    end
                end
            end
            htc_pkg::ST_FIN: begin
                if (go) begin
                    o_cmd.flush = i_stat.held_valid;
                    n_state = htc_pkg::ST_IDLE;
                end
            end
            default: n_state = htc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htc_pkg::ST_IDLE;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last <= n_last;
        end
    end

endmodule

// ----- sv/htc_datapath.sv -----
// Datapath of the HTML text cleaner: byte ring, entity tracking, emit logic, result registers.
`timescale 1ns / 1ps

module htc_datapath #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  htc_pkg::t_cmd  i_cmd,
    input  logic [7:0]     i_byte,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_out_ready,
    output htc_pkg::t_stat o_stat,
    output logic           o_valid,
    output htc_pkg::t_out  o_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, base} + (IW+1)'(off);
        if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
        return s[IW-1:0];
    endfunction

    logic [7:0] r_ring [DEPTH];
    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt, r_pend, n_pend;
    htc_pkg::t_mode r_mode, n_mode;
    logic [9:0] r_val, n_val;
    logic r_ok, n_ok;
    logic [htc_pkg::N_ENT-1:0] r_mask, n_mask;
    logic r_hv, n_hv;
    logic [7:0] r_h, n_h;
    logic r_space, n_space;
    logic [15:0] r_emit, n_emit;
    logic r_lim, n_lim;
    logic [15:0] r_limit;
    logic r_held_v, n_held_v;
    htc_pkg::t_out r_held;
    logic r_ovalid;
    htc_pkg::t_out r_odata;

    logic [IW-1:0] rd_idx;
    logic [7:0] b;
    logic [CW-1:0] cnt_a;
    logic res_v;
    htc_pkg::t_out res;
    logic ws;
    logic is_digit;
    logic [13:0] nv;
    logic [htc_pkg::N_ENT-1:0] mask_b;
    logic matched;
    logic [7:0] mval;
    logic do_fail, do_clear;
    logic push_out;
    htc_pkg::t_out push_data;

    assign rd_idx = ring_add(r_head, r_cnt);
    assign b = r_ring[rd_idx];
    assign cnt_a = r_cnt + CW'(1);
    assign ws = (r_h == htc_pkg::CH_SPACE) || (r_h >= 8'd9 && r_h <= 8'd13);
    assign is_digit = (b >= htc_pkg::CH_ZERO) && (b <= htc_pkg::CH_NINE);
    assign nv = 14'(r_val) * 14'd10 + 14'(b - htc_pkg::CH_ZERO);

    // Candidate named entities that still agree with the byte at this position.
    always_comb begin
        matched = 1'b0;
        mval = '0;
        for (int e = 0; e < htc_pkg::N_ENT; e++) begin
            mask_b[e] = r_mask[e] && (r_cnt < CW'(htc_pkg::ENT_LEN[e]))
                        && (htc_pkg::ENT_SEQ[e][r_cnt[2:0]] == b);
            if (mask_b[e] && CW'(htc_pkg::ENT_LEN[e]) == cnt_a) begin
                matched = 1'b1;
                mval = mval | htc_pkg::ENT_VAL[e];
            end
        end
    end

    always_comb begin
        n_head = r_head;
        n_cnt = r_cnt;
        n_pend = r_pend;
        n_mode = r_mode;
        n_val = r_val;
        n_ok = r_ok;
        n_mask = r_mask;
        n_hv = r_hv;
        n_h = r_h;
        n_space = r_space;
        n_emit = r_emit;
        n_lim = r_lim;
        res_v = 1'b0;
        res = '0;
        do_fail = 1'b0;
        do_clear = 1'b0;

        if (i_cmd.load) begin
            n_pend = CW'(1);
        end

        if (i_cmd.step) begin
            if (r_lim) begin
                n_pend = '0;
                n_hv = 1'b0;
            end else if (r_hv) begin
                if (ws) begin
                    n_space = (r_emit != 16'd0);
                    n_hv = 1'b0;
                end else if (r_space) begin
                    if (({1'b0, r_emit} + 17'd2) > {1'b0, r_limit}) begin
                        n_lim = 1'b1;
                        n_hv = 1'b0;
                    end else begin
                        n_emit = r_emit + 16'd1;
                        n_space = 1'b0;
                        res_v = 1'b1;
                        res.out_byte = htc_pkg::CH_SPACE;
                        res.has_byte = 1'b1;
                        res.text_length = n_emit;
                    end
                end else begin
                    n_hv = 1'b0;
                    if (r_emit >= r_limit) begin
                        n_lim = 1'b1;
                    end else begin
                        n_emit = r_emit + 16'd1;
                        n_lim = (n_emit >= r_limit);
                        res_v = 1'b1;
                        res.out_byte = r_h;
                        res.has_byte = 1'b1;
                        res.text_length = n_emit;
                    end
                end
            end else begin
                n_pend = r_pend - CW'(1);
                unique case (r_mode)
                    htc_pkg::MODE_TAG: begin
                        if (b == htc_pkg::CH_GT) n_mode = htc_pkg::MODE_TEXT;
                        n_head = ring_add(r_head, CW'(1));
                    end
                    htc_pkg::MODE_ENTITY: begin
                        if (b == htc_pkg::CH_SEMI) begin
                            if (matched) begin
                                do_clear = 1'b1;
                                n_hv = 1'b1;
                                n_h = mval;
                            end else if (r_ok && r_cnt >= CW'(2)) begin
                                do_clear = 1'b1;
                                if (r_val >= 10'h20 && r_val < 10'h7F) begin
                                    n_hv = 1'b1;
                                    n_h = r_val[7:0];
                                end
                            end else if (r_cnt < CW'(htc_pkg::WINDOW_LEN)) begin
                                do_clear = 1'b1;
                            end else begin
                                do_fail = 1'b1;
                            end
                        end else begin
                            n_mask = mask_b;
                            n_cnt = cnt_a;
                            if (r_cnt == CW'(1)) begin
                                n_ok = (b == htc_pkg::CH_HASH);
                            end else if (r_ok && is_digit && r_val < htc_pkg::NUM_CAP) begin
                                n_val = (nv > htc_pkg::NUM_SAT) ? 10'd1023 : nv[9:0];
                            end else begin
                                n_ok = 1'b0;
                            end
                            if ((cnt_a >= CW'(htc_pkg::WINDOW_LEN) && !n_ok)
                                || cnt_a >= CW'(DEPTH)) begin
                                do_fail = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (b == htc_pkg::CH_LT) begin
                            n_mode = htc_pkg::MODE_TAG;
                            n_head = ring_add(r_head, CW'(1));
                        end else if (b == htc_pkg::CH_AMP) begin
                            n_mode = htc_pkg::MODE_ENTITY;
                            n_cnt = CW'(1);
                            n_val = '0;
                            n_ok = 1'b1;
                            n_mask = '1;
                        end else begin
                            n_hv = 1'b1;
                            n_h = b;
                            n_head = ring_add(r_head, CW'(1));
                        end
                    end
                endcase
            end
        end

        if (i_cmd.fail) do_fail = 1'b1;

        if (do_clear) begin
            n_mode = htc_pkg::MODE_TEXT;
            n_cnt = '0;
            n_val = '0;
            n_ok = 1'b0;
            n_head = ring_add(r_head, cnt_a);
        end

        // The '&' is emitted and every byte behind it goes back to the pending queue.
        if (do_fail) begin
            n_mode = htc_pkg::MODE_TEXT;
            n_cnt = '0;
            n_val = '0;
            n_ok = 1'b0;
            n_head = ring_add(r_head, CW'(1));
            n_pend = r_pend + r_cnt - CW'(1);
            n_hv = 1'b1;
            n_h = htc_pkg::CH_AMP;
        end

        if (i_cmd.done) begin
            res_v = 1'b1;
            res.text_done = 1'b1;
            res.text_length = r_emit;
            n_mode = htc_pkg::MODE_TEXT;
            n_cnt = '0;
            n_pend = '0;
            n_val = '0;
            n_ok = 1'b0;
            n_hv = 1'b0;
            n_space = 1'b0;
            n_emit = '0;
            n_lim = 1'b0;
        end
    end

    assign push_out = (res_v && r_held_v) || i_cmd.flush;
    assign n_held_v = res_v ? 1'b1 : (i_cmd.flush ? 1'b0 : r_held_v);

    always_comb begin
        push_data = r_held;
        push_data.run_last = i_cmd.flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt <= '0;
            r_pend <= '0;
            r_mode <= htc_pkg::MODE_TEXT;
            r_val <= '0;
            r_ok <= 1'b0;
            r_hv <= 1'b0;
            r_space <= 1'b0;
            r_emit <= '0;
            r_lim <= 1'b0;
            r_limit <= htc_pkg::LIMIT_RESET;
            r_held_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_cnt <= n_cnt;
            r_pend <= n_pend;
            r_mode <= n_mode;
            r_val <= n_val;
            r_ok <= n_ok;
            r_hv <= n_hv;
            r_space <= n_space;
            r_emit <= n_emit;
            r_lim <= n_lim;
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_held_v <= n_held_v;
            if (push_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_h <= n_h;
        if (i_cmd.load) r_ring[rd_idx] <= i_byte;
        if (res_v) r_held <= res;
        if (push_out) r_odata <= push_data;
    end

    assign o_stat.work = r_hv || (r_pend != '0);
    assign o_stat.ent_open = (r_mode == htc_pkg::MODE_ENTITY) && !r_lim;
    assign o_stat.held_valid = r_held_v;
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_valid = r_ovalid;
    assign o_data = r_odata;

endmodule

// ----- sv/html_text_cleaner.sv -----
// Top level of the HTML text cleaner.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_data  (htc_pkg::t_in)
//   output    out        o_valid / i_ready   o_data  (htc_pkg::t_out)
//   config    in         i_cfg_we            i_cfg_data (output_limit)
//
// One byte is taken per transfer; a plain character is first classified by the step unit,
// then emitted into the hold register, and is pushed to the output register when its run
// ends; only then is the next byte taken. A pending space adds a step of its own, and each
// buffered byte replayed after a failed entity is stepped again.
// The last byte of a text adds a done step and a finish state for the done result.
// The input waits on the shared single-byte step unit that works through the byte ring.
// Reset is synchronous and active low; the output limit returns to 1024.
// A stalled output holds the step unit once the one-result hold register is full.
`timescale 1ns / 1ps

module html_text_cleaner #(
    parameter int ENTITY_BUFFER_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  htc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output htc_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data
);

    htc_pkg::t_cmd cmd;
    htc_pkg::t_stat stat;

    htc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_data.in_last),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    htc_datapath #(
        .DEPTH (ENTITY_BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_byte      (i_data.in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule

// ----- sv/htc_checker.sv -----
// Port-level checker of the HTML text cleaner and its bind.
`timescale 1ns / 1ps

module htc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input htc_pkg::t_out o_data
);

    // A result waiting for transfer keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    // The done result carries no character and closes its run.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.text_done |-> o_data.run_last && !o_data.has_byte)
        else $error("malformed done result");

    // A result without a character carries a zero byte.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_byte |-> o_data.out_byte == 8'd0)
        else $error("nonzero byte without character");

    // A character result always counts at least itself.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.has_byte |-> o_data.text_length != 16'd0)
        else $error("character with zero length");

    // Only one byte is in work at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while busy");

endmodule

bind html_text_cleaner htc_checker u_htc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the HTML text cleaner.
`timescale 1ns / 1ps

class text_scoreboard;
    htc_pkg::t_out pending_q[$];
    int            errors;

    // Predictor state.
    logic [15:0] out_limit;
    int          mode;        // 0 text, 1 tag, 2 entity
    logic [7:0]  ent_buf[16];
    int          ent_cnt;
    int          num_val;
    bit          num_ok;
    bit          space_pend;
    int          emitted;
    bit          at_limit;

    function void clear_stream();
        mode = 0;
        ent_cnt = 0;
        num_val = 0;
        num_ok = 0;
        space_pend = 0;
        emitted = 0;
        at_limit = 0;
    endfunction

    function void power_up();
        out_limit = 16'd1024;
        errors = 0;
        clear_stream();
    endfunction

    function void push_result(logic [7:0] ch, bit has, bit done);
        htc_pkg::t_out r;
        r.out_byte = ch;
        r.has_byte = has;
        r.text_done = done;
        r.text_length = emitted[15:0];
        r.run_last = 0;
        pending_q.push_back(r);
    endfunction

    function bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void emit_char(logic [7:0] c);
        if (at_limit) return;
        if (is_space(c)) begin
            space_pend = emitted > 0;
            return;
        end
        if (space_pend) begin
            if (emitted + 2 > out_limit) begin
                at_limit = 1;
                return;
            end
            emitted++;
            push_result(htc_pkg::CH_SPACE, 1, 0);
            space_pend = 0;
        end
        if (emitted >= out_limit) begin
            at_limit = 1;
            return;
        end
        emitted++;
        push_result(c, 1, 0);
        if (emitted >= out_limit) at_limit = 1;
    endfunction

    function void drop_entity();
        mode = 0;
        ent_cnt = 0;
        num_val = 0;
        num_ok = 0;
    endfunction

    // A failed entity emits '&' and replays the rest of the buffer as input.
    function automatic void fail_entity();
        logic [7:0] held[16];
        int n;
        n = ent_cnt;
        held = ent_buf;
        drop_entity();
        emit_char(htc_pkg::CH_AMP);
        for (int k = 1; k < n; k++) feed(held[k]);
    endfunction

    function int named_match();
        for (int e = 0; e < htc_pkg::N_ENT; e++) begin
            if (htc_pkg::ENT_LEN[e] == ent_cnt) begin
                bit ok;
                ok = 1;
                for (int k = 0; k < ent_cnt; k++)
                    if (ent_buf[k] != htc_pkg::ENT_SEQ[e][k]) ok = 0;
                if (ok) return htc_pkg::ENT_VAL[e];
            end
        end
        return -1;
    endfunction

    function automatic void entity_byte(logic [7:0] b);
        int p;
        int m;
        int v;
        p = ent_cnt;
        if (p >= 16) begin
            fail_entity();
            return;
        end
        ent_buf[p] = b;
        ent_cnt = p + 1;
        if (b == htc_pkg::CH_SEMI) begin
            m = named_match();
            if (m >= 0) begin
                drop_entity();
                emit_char(m[7:0]);
                return;
            end
            if (num_ok && p >= 2) begin
                v = num_val;
                drop_entity();
                if (v >= 32 && v < 127) emit_char(v[7:0]);
                return;
            end
            if (p < htc_pkg::WINDOW_LEN) begin
                drop_entity();
                return;
            end
            fail_entity();
            return;
        end
        if (p == 1) num_ok = (b == htc_pkg::CH_HASH);
        else if (num_ok && b >= htc_pkg::CH_ZERO && b <= htc_pkg::CH_NINE && num_val < 512) begin
            v = num_val * 10 + (b - htc_pkg::CH_ZERO);
            num_val = v > 1023 ? 1023 : v;
        end else num_ok = 0;
        if ((ent_cnt >= htc_pkg::WINDOW_LEN && !num_ok) || ent_cnt >= 16) fail_entity();
    endfunction

    function automatic void feed(logic [7:0] b);
        if (at_limit) return;
        if (mode == 1) begin
            if (b == htc_pkg::CH_GT) mode = 0;
            return;
        end
        if (mode == 2) begin
            entity_byte(b);
            return;
        end
        if (b == htc_pkg::CH_LT) mode = 1;
        else if (b == htc_pkg::CH_AMP) begin
            mode = 2;
            ent_buf[0] = b;
            ent_cnt = 1;
            num_val = 0;
            num_ok = 1;
        end else emit_char(b);
    endfunction

    function void note_input(htc_pkg::t_in it);
        int base;
        base = pending_q.size();
        feed(it.in_byte);
        if (it.in_last) begin
            while (mode == 2 && !at_limit) fail_entity();
            push_result(8'h00, 0, 1);
            clear_stream();
        end
        if (pending_q.size() > base) pending_q[$].run_last = 1;
    endfunction

    function void check_result(htc_pkg::t_out got);
        htc_pkg::t_out exp;
        if (pending_q.size() == 0) begin
            report_error($sformatf("unexpected result %h", got));
            return;
        end
        exp = pending_q.pop_front();
        if (got.out_byte !== exp.out_byte) report_error($sformatf("out_byte %h exp %h",
            got.out_byte, exp.out_byte));
        if (got.has_byte !== exp.has_byte) report_error("has_byte mismatch");
        if (got.text_done !== exp.text_done) report_error("text_done mismatch");
        if (got.text_length !== exp.text_length) report_error($sformatf(
            "text_length %0d exp %0d", got.text_length, exp.text_length));
        if (got.run_last !== exp.run_last) report_error("run_last mismatch");
    endfunction

    function void report_error(string msg);
        $display("%0t ERROR: %s", $realtime, msg);
        errors++;
    endfunction
endclass

module tb_top;
    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_valid = 0;
    logic          o_ready;
    htc_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_ready = 0;
    htc_pkg::t_out o_data;
    logic          i_cfg_we = 0;
    logic [15:0]   i_cfg_data = '0;

    text_scoreboard sb;
    bit             hold_off = 0;
    bit             long_stall = 0;

    html_text_cleaner i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Transfers are noted at the rising edge on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    // Receiver: its own stall pattern, plus one long hold-off.
    initial begin
        int k;
        k = 0;
        forever begin
            @(negedge i_clk);
            k++;
            if (long_stall) i_ready <= 0;
            else if (k % 300 < 100) i_ready <= 1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Valid stays high after a transfer so that the next byte can follow at once;
    // a caller that pauses lowers it first.
    task automatic send_byte(logic [7:0] b, bit last);
        i_valid <= 1;
        i_data <= '{in_byte: b, in_last: last};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit last);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], last && k == s.len() - 1);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.out_limit = v;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        string frag;
        frag = "&<>;#0159 \tamplgtquotnbspmiddot";
        r = $urandom_range(0, 9);
        if (r < 4) return frag[$urandom_range(0, frag.len() - 1)];
        if (r < 8) return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int n);
        string ents[12];
        int    sent;
        ents = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;", "&nbsp;", "&ensp;",
                 "&emsp;", "&middot;", "&#65;", "&#999999;", "&bogus;"};
        sent = 0;
        while (sent < n) begin
            int burst;
            int idx;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < n; b++) begin
                if ($urandom_range(0, 5) == 0) begin
                    idx = $urandom_range(0, 11);
                    send_text(ents[idx], 0);
                    sent += ents[idx].len();
                end else begin
                    send_byte(pick_byte(), $urandom_range(0, 25) == 0);
                    sent++;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        send_byte("x", 1);
    endtask

    initial begin
        sb = new();
        sb.power_up();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // Directed: entities, decimal edge cases, tags, whitespace and overflow.
        send_text("  a<b x>&amp;&lt;&gt;&quot;&#39;&nbsp;&ensp;&emsp;&middot;z", 0);
        send_text("&#32;&#126;&#127;&#;&#600;&#5123;&zz;&abcdefghijklm; \t\n", 1);
        send_text("&#00000000000000065;&xy<i>&", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        write_limit(16'd1);
        send_text("ab cd", 1);
        write_limit(16'd3);
        send_text("a bc d", 1);
        write_limit(16'hFFFF);
        // Long receiver hold-off while input keeps coming.
        fork
            begin
                long_stall = 1;
                repeat (400) @(negedge i_clk);
                long_stall = 0;
            end
            send_text("hello world &amp; more text here to fill the pipe", 1);
        join
        random_phase(90);
        write_limit(16'd7);
        random_phase(40);
        write_limit(16'd1024);
        random_phase(70);
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/htc_pkg.sv
sv/htc_ctrl.sv
sv/htc_datapath.sv
sv/html_text_cleaner.sv
sv/htc_checker.sv
dv/tb_top.sv
